// File: design/cab_pkg.sv
// ----------------------------------------------------------------------------
// CAN autobaud controller package
// Shared constants, configuration and result types for the autobaud block.
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

	// Default highest bit-rate index before the sweep wraps to zero.
	localparam int unsigned MAX_SPEED_INDEX_DEF = 3;

	// Widths of the fixed fields.
	localparam int unsigned MS_W      = 8;
	localparam int unsigned FRAMES_W  = 2;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned TIMER_W   = 17;
	localparam int unsigned PEND_W    = 8;
	localparam int unsigned TOTAL_W   = 32;
	localparam int unsigned SPEED_OUT_W = 2;

	// Configuration port geometry.
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Saturation limits.
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [PEND_W-1:0]  PEND_MAX  = {PEND_W{1'b1}};

	// Reset values of the configuration registers.
	localparam logic [TIMEOUT_W-1:0] AB_TIMEOUT_RST = 16'd1000;
	localparam logic [TIMEOUT_W-1:0] RX_TIMEOUT_RST = 16'd3000;

	// Register index, taken from the word address.
	typedef enum logic [1:0] {
		REG_AB_TIMEOUT = 2'd0,
		REG_RX_TIMEOUT = 2'd1,
		REG_NO_RX      = 2'd2
	} reg_idx_t;

	// Operating mode.
	localparam logic MODE_AUTOBAUD = 1'b0;
	localparam logic MODE_NORMAL   = 1'b1;

	// Configuration handed to the tick logic.
	typedef struct packed {
		logic [TIMEOUT_W-1:0] ab_timeout;
		logic [TIMEOUT_W-1:0] rx_timeout;
		logic                 no_rx;
	} cfg_t;

	// One result of a tick.
	typedef struct packed {
		logic                   mode;
		logic [SPEED_OUT_W-1:0] speed_index;
		logic                   init_request;
		logic                   silent;
		logic                   configured;
		logic [TOTAL_W-1:0]     frames_total;
	} res_t;

endpackage : cab_pkg

`default_nettype wire

// File: design/cab_core.sv
// ----------------------------------------------------------------------------
// CAN autobaud tick logic
// Holds the mode state and computes the next state and result of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module cab_core
	import cab_pkg::*;
#(
	parameter int unsigned MAX_SPEED_INDEX = MAX_SPEED_INDEX_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [MS_W-1:0]     ms,
	input  wire logic [FRAMES_W-1:0] frames,
	input  wire logic                ack,
	input  wire cfg_t                cfg,
	output res_t                     res
);

	localparam int unsigned SPEED_W = $clog2(MAX_SPEED_INDEX + 1);

	// State registers.
	logic               mode_q;
	logic [SPEED_W-1:0] speed_q;
	logic               await_init_q;
	logic               await_normal_q;
	logic               silent_q;
	logic [TIMER_W-1:0] dwell_q;
	logic [TIMER_W-1:0] quiet_q;
	logic [PEND_W-1:0]  pend_q;
	logic [TOTAL_W-1:0] total_q;

	// Next-state values.
	logic               mode_d;
	logic [SPEED_W-1:0] speed_d;
	logic               await_init_d;
	logic               await_normal_d;
	logic               silent_d;
	logic [TIMER_W-1:0] dwell_d;
	logic [TIMER_W-1:0] quiet_d;
	logic [PEND_W-1:0]  pend_d;
	logic [TOTAL_W-1:0] total_d;
	logic               cfg_done;

	logic               hold;
	logic [PEND_W:0]    pend_sum;
	logic [TIMER_W:0]   dwell_sum;
	logic [TIMER_W:0]   quiet_sum;
	logic [SPEED_W:0]   speed_inc;

	// Saturating sums used by the tick.
	assign pend_sum  = {1'b0, pend_q} + (PEND_W+1)'(frames);
	assign dwell_sum = {1'b0, dwell_q} + (TIMER_W+1)'(ms);
	assign quiet_sum = {1'b0, quiet_q} + (TIMER_W+1)'(ms);
	assign speed_inc = {1'b0, speed_q} + (SPEED_W+1)'(1);

	// One tick: acknowledge handshake with the controller, then the timers.
	always_comb begin
		mode_d         = mode_q;
		speed_d        = speed_q;
		await_init_d   = await_init_q;
		await_normal_d = await_normal_q;
		silent_d       = silent_q;
		dwell_d        = dwell_q;
		quiet_d        = quiet_q;
		total_d        = total_q + TOTAL_W'(frames);
		pend_d         = pend_sum[PEND_W] ? PEND_MAX : pend_sum[PEND_W-1:0];
		cfg_done       = 1'b0;
		hold           = 1'b0;

		// Wait for the controller to enter init mode, then configure it.
		if (await_init_q) begin
			if (!ack) begin
				hold = 1'b1;
			end else begin
				await_init_d   = 1'b0;
				silent_d       = (mode_q == MODE_AUTOBAUD);
				await_normal_d = 1'b1;
				cfg_done       = 1'b1;
			end
		end

		// Wait for the controller to leave init mode.
		if (!hold && await_normal_d) begin
			if (ack) begin
				hold = 1'b1;
			end else begin
				await_normal_d = 1'b0;
				pend_d         = '0;
			end
		end

		if (!hold) begin
			if (mode_q == MODE_AUTOBAUD) begin
				// Dwell on one bit rate, then step to the next.
				dwell_d = dwell_sum[TIMER_W] ? TIMER_MAX : dwell_sum[TIMER_W-1:0];
				if (dwell_d > TIMER_W'(cfg.ab_timeout)) begin
					if (speed_inc > (SPEED_W+1)'(MAX_SPEED_INDEX)) begin
						speed_d = '0;
					end else begin
						speed_d = speed_inc[SPEED_W-1:0];
					end
					await_init_d = 1'b1;
					dwell_d      = '0;
				end
				// Any reception locks the bit rate.
				if (pend_d != '0) begin
					mode_d       = MODE_NORMAL;
					quiet_d      = '0;
					await_init_d = 1'b1;
				end
			end else if (!cfg.no_rx) begin
				// Receive timeout in normal mode.
				quiet_d = quiet_sum[TIMER_W] ? TIMER_MAX : quiet_sum[TIMER_W-1:0];
				if (pend_d != '0) begin
					quiet_d = '0;
					pend_d  = '0;
				end
				if (quiet_d > TIMER_W'(cfg.rx_timeout)) begin
					mode_d  = MODE_AUTOBAUD;
					dwell_d = TIMER_W'(cfg.ab_timeout);
				end
			end
		end
	end

	// Result of the tick as seen after the update.
	always_comb begin
		res.mode         = mode_d;
		res.speed_index  = SPEED_OUT_W'(speed_d);
		res.init_request = await_init_d;
		res.silent       = silent_d;
		res.configured   = cfg_done;
		res.frames_total = total_d;
	end

	// State update on each processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_AUTOBAUD;
			speed_q        <= '0;
			await_init_q   <= 1'b1;
			await_normal_q <= 1'b0;
			silent_q       <= 1'b0;
			dwell_q        <= '0;
			quiet_q        <= '0;
			pend_q         <= '0;
			total_q        <= '0;
		end else if (step) begin
			mode_q         <= mode_d;
			speed_q        <= speed_d;
			await_init_q   <= await_init_d;
			await_normal_q <= await_normal_d;
			silent_q       <= silent_d;
			dwell_q        <= dwell_d;
			quiet_q        <= quiet_d;
			pend_q         <= pend_d;
			total_q        <= total_d;
		end
	end

endmodule : cab_core

`default_nettype wire

// File: design/can_autobaud_controller_unit.sv
// ----------------------------------------------------------------------------
// CAN autobaud controller unit
// Poll-tick driven bit-rate search and mode control for a CAN controller.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the input channel (in_valid, in_stall) is one poll
// tick: elapsed milliseconds, frames received and the init acknowledge level.
// Each tick gives exactly one transaction on the output channel (out_valid,
// out_stall) with the mode, bit-rate index, init request, silent bit, a
// configured flag and the wrapping frame total.
// A tick is captured in an input register and processed once the output
// register is free, where the mode state is updated and the result is
// written to the output register and out_valid is raised; one tick can be
// accepted every cycle while the receiver does not stall. The rate is set
// by the state update between the input register and the result register.
// When the receiver stalls, the result waits in the output register, one
// more tick waits in the input register, and in_stall then rises.
// Reset clears the mode state (autobaud, index 0, init requested) and loads
// the timeout registers with their defaults. The user writes them through
// the APB port only while no tick is in flight; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module can_autobaud_controller_unit
	import cab_pkg::*;
#(
	parameter int unsigned MAX_SPEED_INDEX = MAX_SPEED_INDEX_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// Configuration port.
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [PADDR_W-1:0]     paddr,
	input  wire logic [PDATA_W-1:0]     pwdata,
	output logic      [PDATA_W-1:0]     prdata,
	output logic                        pready,

	// Tick input channel.
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [MS_W-1:0]        elapsed_ms,
	input  wire logic [FRAMES_W-1:0]    frames_received,
	input  wire logic                   init_ack,

	// Result output channel.
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        mode,
	output logic [SPEED_OUT_W-1:0]      speed_index,
	output logic                        init_request,
	output logic                        silent,
	output logic                        configured,
	output logic [TOTAL_W-1:0]          frames_total
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	logic                valid_s1;
	logic [MS_W-1:0]     ms_s1;
	logic [FRAMES_W-1:0] frames_s1;
	logic                ack_s1;

	logic out_valid_q;
	res_t res;
	res_t res_q;
	logic out_free;
	logic adv;
	logic in_take;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ab_timeout <= AB_TIMEOUT_RST;
			cfg_q.rx_timeout <= RX_TIMEOUT_RST;
			cfg_q.no_rx      <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_AB_TIMEOUT: cfg_q.ab_timeout <= pwdata[TIMEOUT_W-1:0];
				REG_RX_TIMEOUT: cfg_q.rx_timeout <= pwdata[TIMEOUT_W-1:0];
				REG_NO_RX:      cfg_q.no_rx      <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_AB_TIMEOUT: prdata = PDATA_W'(cfg_q.ab_timeout);
			REG_RX_TIMEOUT: prdata = PDATA_W'(cfg_q.rx_timeout);
			REG_NO_RX:      prdata = PDATA_W'(cfg_q.no_rx);
			default:        prdata = '0;
		endcase
	end

	// Flow control: a tick advances when the output register is free.
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ms_s1     <= elapsed_ms;
			frames_s1 <= frames_received;
			ack_s1    <= init_ack;
		end
	end

	// Mode state and tick logic.
	cab_core #(
		.MAX_SPEED_INDEX(MAX_SPEED_INDEX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.ms     (ms_s1),
		.frames (frames_s1),
		.ack    (ack_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign mode         = res_q.mode;
	assign speed_index  = res_q.speed_index;
	assign init_request = res_q.init_request;
	assign silent       = res_q.silent;
	assign configured   = res_q.configured;
	assign frames_total = res_q.frames_total;

endmodule : can_autobaud_controller_unit

`default_nettype wire
